@@ sv/sha_pkg.sv @@
// Package for the SHA-256 digest core: payload types, controller commands and round constants.
package sha_pkg;

	typedef struct packed {
		logic [7:0] message_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_FIN,
		ST_PAD,
		ST_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       take_byte;   // write the request's byte into the block buffer
		logic       start_comp;  // load working variables from the chain
		logic       round;       // run one compression round
		logic       finish_comp; // add working variables into the chain
		logic       pad_write;   // write one padding byte at the fill position
		logic       out_shift;   // move to the next digest word
		logic       restart;     // return to initial hash values
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       block_full;  // padded block complete, waiting for compression
		logic       fill_last;   // 63 bytes held, the next byte completes the block
		logic       last_round;  // round 63 in progress
		logic       pad_done;    // the block just compressed carried the length field
	} stat_t;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_OFFSET = 6'd56;

endpackage

@@ sv/sha_ctrl.sv @@
// Controller state machine of the SHA-256 digest core.
module sha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  sha_pkg::in_item_t in_item,
	input  logic            out_stall,
	input  sha_pkg::stat_t  stat,
	output logic            in_stall,
	output logic            out_valid,
	output logic            out_last,
	output sha_pkg::cmd_t   cmd
);

	sha_pkg::state_t state_q, state_d;
	logic            eom_q;      // message end pending after the current compression
	logic [2:0]      word_q;
	logic            accept;

	assign accept = in_valid && (state_q == sha_pkg::ST_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sha_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_item.byte_present && stat.fill_last)
						state_d = sha_pkg::ST_COMP;
					else if (in_item.end_of_message)
						state_d = sha_pkg::ST_PAD;
				end
			end
			sha_pkg::ST_COMP: begin
				if (stat.last_round)
					state_d = sha_pkg::ST_FIN;
			end
			sha_pkg::ST_FIN: begin
				if (!eom_q)
					state_d = sha_pkg::ST_IDLE;
				else if (stat.pad_done)
					state_d = sha_pkg::ST_OUT;
				else
					state_d = sha_pkg::ST_PAD;
			end
			sha_pkg::ST_PAD: begin
				if (stat.block_full)
					state_d = sha_pkg::ST_COMP;
			end
			sha_pkg::ST_OUT: begin
				if (!out_stall && word_q == 3'd7)
					state_d = sha_pkg::ST_IDLE;
			end
			default: state_d = sha_pkg::ST_IDLE;
		endcase
	end

	// Outputs and commands.
	always_comb begin
		cmd = '0;
		in_stall = (state_q != sha_pkg::ST_IDLE);
		out_valid = (state_q == sha_pkg::ST_OUT);
		out_last = (word_q == 3'd7);
		case (state_q)
			sha_pkg::ST_IDLE: begin
				cmd.take_byte = accept && in_item.byte_present;
				cmd.start_comp = accept && in_item.byte_present && stat.fill_last;
			end
			sha_pkg::ST_COMP: begin
				cmd.round = 1'b1;
			end
			sha_pkg::ST_FIN: begin
				cmd.finish_comp = 1'b1;
			end
			sha_pkg::ST_PAD: begin
				cmd.pad_write = !stat.block_full;
				cmd.start_comp = stat.block_full;
			end
			sha_pkg::ST_OUT: begin
				cmd.out_shift = !out_stall;
				cmd.restart = !out_stall && word_q == 3'd7;
			end
			default: cmd = '0;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::ST_IDLE;
			eom_q <= 1'b0;
			word_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept)
				eom_q <= in_item.end_of_message;
			else if (cmd.restart)
				eom_q <= 1'b0;
			if (cmd.out_shift)
				word_q <= word_q + 3'd1;
		end
	end

endmodule

@@ sv/sha_dp.sv @@
// Datapath of the SHA-256 digest core: block buffer, schedule, rounds and chaining words.
module sha_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  sha_pkg::in_item_t in_item,
	input  sha_pkg::cmd_t     cmd,
	input  logic              out_last,
	output sha_pkg::stat_t    stat,
	output sha_pkg::out_item_t out_item
);

	logic [31:0] w_q [16];    // block bytes while filling, rolling schedule during rounds
	logic [5:0]  fill_q;
	logic        full_q;      // padded block complete, waiting for compression
	logic [60:0] count_q;
	logic [31:0] chain_q [8];
	logic [31:0] var_q [8];
	logic [5:0]  round_q;
	logic [2:0]  word_q;
	logic        marked_q;
	logic        extra_q;     // mark left no room for the length, rest of block is zeros
	logic        lenwr_q;     // current padded block carries the length field
	logic [63:0] bits;
	logic [7:0]  pad_byte;
	logic [7:0]  wr_byte;
	logic [31:0] w_new, w_cur, s0, s1, x15, x2, e, a, t1, t2;

	assign bits = {count_q, 3'b000};

	// Padding byte: mark first, zeros, then the length field in the final block.
	always_comb begin
		if (!marked_q)
			pad_byte = sha_pkg::PAD_MARK;
		else if (fill_q >= sha_pkg::LEN_OFFSET && !extra_q)
			pad_byte = bits[{~fill_q[2:0], 3'b000} +: 8];
		else
			pad_byte = 8'h00;
		wr_byte = cmd.take_byte ? in_item.message_byte : pad_byte;
	end

	// Status.
	always_comb begin
		stat.block_full = full_q;
		stat.fill_last = (fill_q == 6'd63);
		stat.last_round = (round_q == 6'd63);
		stat.pad_done = marked_q && lenwr_q;
	end

	// Round logic.
	always_comb begin
		x15 = w_q[1];
		x2 = w_q[14];
		s0 = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
		s1 = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		w_cur = (round_q < 6'd16) ? w_q[0] : w_new;
		e = var_q[4];
		a = var_q[0];
		t1 = var_q[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
			+ ((e & var_q[5]) ^ (~e & var_q[6])) + sha_pkg::ROUND_K[round_q] + w_cur;
		t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
			+ ((a & var_q[1]) ^ (a & var_q[2]) ^ (var_q[1] & var_q[2]));
	end

	// Block bytes go straight into the schedule window, big-endian within each word.
	always_ff @(posedge clk) begin
		if (cmd.take_byte || cmd.pad_write) begin
			w_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= wr_byte;
		end else if (cmd.round) begin
			for (int j = 0; j < 15; j++)
				w_q[j] <= w_q[j + 1];
			w_q[15] <= w_cur;
		end
	end

	// Working variables.
	always_ff @(posedge clk) begin
		if (cmd.start_comp) begin
			for (int j = 0; j < 8; j++)
				var_q[j] <= chain_q[j];
		end else if (cmd.round) begin
			for (int j = 1; j < 8; j++)
				var_q[j] <= var_q[j - 1];
			var_q[4] <= var_q[3] + t1;
			var_q[0] <= t1 + t2;
		end
	end

	// Counters and chaining words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			full_q <= 1'b0;
			count_q <= '0;
			round_q <= '0;
			word_q <= '0;
			marked_q <= 1'b0;
			extra_q <= 1'b0;
			lenwr_q <= 1'b0;
			for (int j = 0; j < 8; j++)
				chain_q[j] <= sha_pkg::INIT_HASH[j];
		end else begin
			if (cmd.take_byte) begin
				fill_q <= fill_q + 6'd1;
				count_q <= count_q + 61'd1;
			end
			if (cmd.pad_write) begin
				marked_q <= 1'b1;
				fill_q <= fill_q + 6'd1;
				if (fill_q == 6'd63) begin
					full_q <= 1'b1;
					lenwr_q <= marked_q && !extra_q;
					extra_q <= 1'b0;
				end else if (!marked_q) begin
					// A mark at or beyond the length field pushes the length to the next block.
					extra_q <= (fill_q >= sha_pkg::LEN_OFFSET);
				end
			end
			if (cmd.start_comp) begin
				full_q <= 1'b0;
				round_q <= '0;
			end
			if (cmd.round)
				round_q <= round_q + 6'd1;
			if (cmd.finish_comp) begin
				fill_q <= '0;
				for (int j = 0; j < 8; j++)
					chain_q[j] <= chain_q[j] + var_q[j];
			end
			if (cmd.out_shift)
				word_q <= word_q + 3'd1;
			if (cmd.restart) begin
				fill_q <= '0;
				count_q <= '0;
				marked_q <= 1'b0;
				extra_q <= 1'b0;
				lenwr_q <= 1'b0;
				for (int j = 0; j < 8; j++)
					chain_q[j] <= sha_pkg::INIT_HASH[j];
			end
		end
	end

	assign out_item.digest_word = chain_q[word_q];
	assign out_item.word_index = word_q;
	assign out_item.last_word = out_last;

endmodule

@@ sv/sha256_digest_core.sv @@
// Top level of the SHA-256 digest core.
// A byte request is taken while the core is idle; the 64th byte of a block then stalls input
// for 64 rounds, one per cycle, and a fold of the working variables into the chaining words.
// An end request takes per padded block (one or two) one padding byte per cycle, a load and
// the compression, then eight digest requests, one per cycle unless stalled.
// Asynchronous active-low reset restores the initial hash values and empties the buffer.
module sha256_digest_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sha_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output sha_pkg::out_item_t  out_data
);

	sha_pkg::cmd_t  cmd;
	sha_pkg::stat_t stat;
	logic           out_last;

	sha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_item   (in_data),
		.out_stall (out_stall),
		.stat      (stat),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_last  (out_last),
		.cmd       (cmd)
	);

	sha_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_data),
		.cmd      (cmd),
		.out_last (out_last),
		.stat     (stat),
		.out_item (out_data)
	);

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the SHA-256 digest core: byte streams in, digest words checked against a model.
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT = 2000000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	sha_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_stall;
	sha_pkg::out_item_t out_data;

	sha256_digest_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Predictor state for the running message.
	logic [31:0]        hash_state [8];
	logic [7:0]         msg_block [64];
	int unsigned        block_fill;
	logic [60:0]        msg_len;
	sha_pkg::out_item_t digest_queue [$];
	int                 fail_count;
	int                 send_idle_pct;
	int                 recv_stall_pct;
	longint             cycle_count;

	function automatic logic [31:0] rotr(logic [31:0] v, int r);
		return (v >> r) | (v << (32 - r));
	endfunction

	// One 64-round compression of the held block into the hash state.
	function automatic void compress_held_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2;
		for (int j = 0; j < 16; j++)
			w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		for (int j = 0; j < 8; j++)
			v[j] = hash_state[j];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[t] + w[t];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int j = 7; j > 0; j--)
				v[j] = v[j-1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int j = 0; j < 8; j++)
			hash_state[j] = hash_state[j] + v[j];
	endfunction

	function automatic void start_new_message();
		for (int j = 0; j < 8; j++)
			hash_state[j] = sha_pkg::INIT_HASH[j];
		block_fill = 0;
		msg_len = '0;
	endfunction

	// Advance the predictor by one request and queue any digest words.
	function automatic void predict_digest(sha_pkg::in_item_t req);
		logic [63:0]        bit_len;
		sha_pkg::out_item_t word;
		if (req.byte_present) begin
			msg_block[block_fill] = req.message_byte;
			block_fill++;
			msg_len++;
			if (block_fill == 64) begin
				compress_held_block();
				block_fill = 0;
			end
		end
		if (!req.end_of_message)
			return;
		bit_len = {msg_len, 3'b000};
		msg_block[block_fill] = sha_pkg::PAD_MARK;
		block_fill++;
		if (block_fill > 56) begin
			while (block_fill < 64)
				msg_block[block_fill++] = 8'h00;
			compress_held_block();
			block_fill = 0;
		end
		while (block_fill < 56)
			msg_block[block_fill++] = 8'h00;
		for (int i = 0; i < 8; i++)
			msg_block[63-i] = bit_len[8*i +: 8];
		compress_held_block();
		for (int i = 0; i < 8; i++) begin
			word.digest_word = hash_state[i];
			word.word_index = 3'(i);
			word.last_word = (i == 7);
			digest_queue.push_back(word);
		end
		start_new_message();
	endfunction

	always #2 clk = ~clk;

	// Receiver stall and result checking.
	always @(posedge clk) begin
		sha_pkg::out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (digest_queue.size() == 0) begin
					$display("%0t: unexpected digest word, expected none, actual %h",
						$time, out_data);
					fail_count++;
				end else begin
					want = digest_queue.pop_front();
					if (out_data.digest_word !== want.digest_word) begin
						$display("%0t: digest_word expected %h actual %h",
							$time, want.digest_word, out_data.digest_word);
						fail_count++;
					end
					if (out_data.word_index !== want.word_index) begin
						$display("%0t: word_index expected %0d actual %0d",
							$time, want.word_index, out_data.word_index);
						fail_count++;
					end
					if (out_data.last_word !== want.last_word) begin
						$display("%0t: last_word expected %0d actual %0d",
							$time, want.last_word, out_data.last_word);
						fail_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Run-length guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Send one request, idling beforehand as the current phase asks.
	// Valid stays high after acceptance until the next request or idle cycle replaces it.
	task automatic send_request(logic [7:0] b, logic present, logic last);
		sha_pkg::in_item_t req;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		req.message_byte = b;
		req.byte_present = present;
		req.end_of_message = last;
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_digest(req);
	endtask

	task automatic wait_for_digests();
		in_valid <= 1'b0;
		while (digest_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_message(int len, logic bare_end);
		for (int i = 0; i < len - (bare_end ? 0 : 1); i++) begin
			if ($urandom_range(9) == 0)
				send_request(8'($urandom), 1'b0, 1'b0);
			send_request(8'($urandom), 1'b1, 1'b0);
		end
		if (bare_end || len == 0)
			send_request(8'($urandom), 1'b0, 1'b1);
		else
			send_request(8'($urandom), 1'b1, 1'b1);
	endtask

	// Empty message, ignored bytes, extreme byte values, a full data block and padding overflow.
	task automatic test_directed();
		send_request(8'hFF, 1'b0, 1'b0);
		send_request(8'h00, 1'b0, 1'b1);
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'hA5, 1'b0, 1'b0);
		send_request(8'hFF, 1'b1, 1'b1);
		send_request(8'h55, 1'b1, 1'b1);
		send_message(64, 1'b0);
		send_message(56, 1'b0);
		wait_for_digests();
	endtask

	// Random short messages with mixed end styles.
	task automatic test_random(int idle_pct, int stall_pct, int msgs);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int m = 0; m < msgs; m++)
			send_message(int'($urandom_range(6)), 1'($urandom_range(1)));
		wait_for_digests();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		start_new_message();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(0, 0, 4);
		test_random(83, 0, 4);
		test_random(0, 83, 4);
		test_random(22, 22, 4);
		recv_stall_pct = 0;
		repeat (400) @(posedge clk);
		if (fail_count == 0 && digest_queue.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
